@@ design/mrgd_pkg.sv @@
// Shared types and constants for the Modbus RTU gap detector.
package mrgd_pkg;

    localparam logic       KIND_TICK = 1'b0;
    localparam logic       KIND_BYTE = 1'b1;

    localparam logic       EVENT_TIMEOUT = 1'b0;
    localparam logic       EVENT_BYTE    = 1'b1;

    localparam logic [15:0] CNT_MAX   = 16'hFFFF;
    localparam logic [15:0] GAP_RESET = 16'd5468;

    localparam int          APB_ADDR_W    = 3;
    localparam int          APB_DATA_W    = 32;
    localparam logic        REG_GAP_TICKS = 1'b0;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic       framing_err;
        logic       overrun_err;
        logic       parity_err;
    } t_item;

    typedef struct packed {
        logic        event_res;
        logic [7:0]  data_out;
        logic        frame_start;
        logic        any_error;
        logic [2:0]  error_bits;
        logic [15:0] error_total;
        logic [15:0] good_total;
    } t_result;

endpackage

@@ design/mrgd_tracker.sv @@
// Gap timer and byte counters: state update and result for one word.
module mrgd_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mrgd_pkg::t_item  i_item,
    input  logic [15:0]      i_gap_ticks,
    output logic             o_emit,
    output mrgd_pkg::t_result o_res
);

    logic [15:0] r_gap_count;
    logic        r_gap_running;
    logic [15:0] r_bad_bytes;
    logic [15:0] r_good_bytes;

    logic [15:0] n_gap_count;
    logic        n_gap_running;
    logic [15:0] n_bad_bytes;
    logic [15:0] n_good_bytes;

    logic [15:0] gap_inc;
    logic [2:0]  errs;
    logic        start;

    assign gap_inc = (r_gap_count != mrgd_pkg::CNT_MAX) ? r_gap_count + 16'd1 : r_gap_count;
    assign errs    = {i_item.framing_err, i_item.overrun_err, i_item.parity_err};
    assign start   = !r_gap_running || (r_gap_count > i_gap_ticks);

    always_comb begin
        n_gap_count   = r_gap_count;
        n_gap_running = r_gap_running;
        n_bad_bytes   = r_bad_bytes;
        n_good_bytes  = r_good_bytes;
        o_emit        = 1'b0;
        o_res         = '0;
        if (i_item.kind == mrgd_pkg::KIND_TICK) begin
            // A stopped timer ignores ticks entirely.
            if (r_gap_running) begin
                n_gap_count = gap_inc;
                if (gap_inc >= i_gap_ticks) begin
                    n_gap_running     = 1'b0;
                    o_emit            = 1'b1;
                    o_res.event_res   = mrgd_pkg::EVENT_TIMEOUT;
                    o_res.error_total = r_bad_bytes;
                    o_res.good_total  = r_good_bytes;
                end
            end
        end else begin
            n_gap_count   = '0;
            n_gap_running = 1'b1;
            if (errs != 3'b000) begin
                if (r_bad_bytes != mrgd_pkg::CNT_MAX) begin
                    n_bad_bytes = r_bad_bytes + 16'd1;
                end
            end else begin
                if (r_good_bytes != mrgd_pkg::CNT_MAX) begin
                    n_good_bytes = r_good_bytes + 16'd1;
                end
            end
            o_emit            = 1'b1;
            o_res.event_res   = mrgd_pkg::EVENT_BYTE;
            o_res.data_out    = i_item.rx_byte;
            o_res.frame_start = start;
            o_res.any_error   = (errs != 3'b000);
            o_res.error_bits  = errs;
            o_res.error_total = n_bad_bytes;
            o_res.good_total  = n_good_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_count   <= '0;
            r_gap_running <= 1'b1;
            r_bad_bytes   <= '0;
            r_good_bytes  <= '0;
        end else if (i_fire) begin
            r_gap_count   <= n_gap_count;
            r_gap_running <= n_gap_running;
            r_bad_bytes   <= n_bad_bytes;
            r_good_bytes  <= n_good_bytes;
        end
    end

endmodule

@@ design/modbus_rtu_gap_detector.sv @@
// Top level of the Modbus RTU gap detector: stream ports, register port, pipeline.
//
//  Port group   Direction  Payload
//  s_axis       in         tuser: kind; tdata: rx_byte, framing_err, overrun_err, parity_err
//  m_axis       out        tuser: event_res; tdata: data_out ... good_total
//  APB          in/out     register 0: gap_ticks (16 bits, reset 5468)
//
// One word per clock is taken while the result register is not stalled; each word goes
// from the input register through the gap timer update into the result register, from
// which its result is driven onto the output.
// A word that yields no result (a tick short of the threshold or a tick while stopped)
// moves on even while the result register is stalled.
// Synchronous active-low reset clears the timer to running at zero and both counters.
module modbus_rtu_gap_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] rx_byte, [8] framing_err, [9] overrun_err, [10] parity_err, [15:11] zero
    input  logic [15:0]                         s_axis_tdata,
    // [0] kind
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] data_out, [8] frame_start, [9] any_error, [12:10] error_bits,
    // [28:13] error_total, [44:29] good_total, [47:45] zero
    output logic [47:0]                         m_axis_tdata,
    // [0] event_res
    output logic                                m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mrgd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mrgd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mrgd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [15:0]       r_gap_ticks;
    logic              r_in_valid;
    mrgd_pkg::t_item   r_in_item;
    logic              r_out_valid;
    mrgd_pkg::t_result r_out_res;

    logic              emit;
    mrgd_pkg::t_result res;
    logic              s1_fire;
    logic              reg_sel;

    // Word index of the register port.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == mrgd_pkg::REG_GAP_TICKS) ?
                     {{(mrgd_pkg::APB_DATA_W-16){1'b0}}, r_gap_ticks} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks <= mrgd_pkg::GAP_RESET;
        end else if (psel && penable && pwrite && pready &&
                     reg_sel == mrgd_pkg::REG_GAP_TICKS) begin
            r_gap_ticks <= pwdata[15:0];
        end
    end

    mrgd_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_item      (r_in_item),
        .i_gap_ticks (r_gap_ticks),
        .o_emit      (emit),
        .o_res       (res)
    );

    assign s1_fire       = r_in_valid && (!emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.kind        <= s_axis_tuser;
            r_in_item.rx_byte     <= s_axis_tdata[7:0];
            r_in_item.framing_err <= s_axis_tdata[8];
            r_in_item.overrun_err <= s_axis_tdata[9];
            r_in_item.parity_err  <= s_axis_tdata[10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.event_res;
    assign m_axis_tdata  = {3'b000, r_out_res.good_total, r_out_res.error_total,
                            r_out_res.error_bits, r_out_res.any_error,
                            r_out_res.frame_start, r_out_res.data_out};

    // A timeout word carries no byte, start flag or error flags.
    a_timeout_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == mrgd_pkg::EVENT_TIMEOUT) |->
            m_axis_tdata[12:0] == 13'd0)
        else $error("timeout word with byte fields set");

    // The error summary agrees with the individual flags.
    a_err_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9] == (m_axis_tdata[12:10] != 3'b000))
        else $error("any_error disagrees with error_bits");

    // A word held in the input register waiting on a full result register stays there.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !s1_fire |=> r_in_valid && $stable(r_in_item))
        else $error("input word lost while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

@@ tb/tb_modbus_rtu_gap_detector.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the Modbus RTU gap detector: stream stimulus, register writes, checks.
module tb_modbus_rtu_gap_detector;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUEUE_DEPTH   = 32;
    localparam int REPORT_MAX    = 10;
    localparam int ADDR_W        = mrgd_pkg::APB_ADDR_W;
    localparam int DATA_W        = mrgd_pkg::APB_DATA_W;
    localparam int ITEM_W        = $bits(mrgd_pkg::t_item);
    localparam logic [ADDR_W-1:0] GAP_TICKS_ADDR =
        ADDR_W'(4 * int'(mrgd_pkg::REG_GAP_TICKS));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] rx_byte, [8] framing_err, [9] overrun_err, [10] parity_err, [15:11] zero
    logic [15:0]           s_axis_tdata = '0;
    // [0] kind
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] data_out, [8] frame_start, [9] any_error, [12:10] error_bits,
    // [28:13] error_total, [44:29] good_total, [47:45] zero
    logic [47:0]           m_axis_tdata;
    // [0] event_res
    logic                  m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Expected gap detector state, kept in step with every accepted word.
    logic [15:0] gap_limit = mrgd_pkg::GAP_RESET;
    logic [15:0] gap_count = '0;
    logic        gap_running = 1'b1;
    logic [15:0] bad_total = '0;
    logic [15:0] good_total = '0;

    mrgd_pkg::t_item   pending_words[$];
    mrgd_pkg::t_result expected_events[$];

    logic in_fire = 1'b0;
    int   mismatches = 0;
    int   stall_cycles = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   queued_words = 0;

    modbus_rtu_gap_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic bit predict_gap_event(input mrgd_pkg::t_item w,
                                             output mrgd_pkg::t_result r);
        logic [2:0] errs;
        logic       starts;
        r = '0;
        if (w.kind == mrgd_pkg::KIND_TICK) begin
            if (!gap_running) return 1'b0;
            if (gap_count != mrgd_pkg::CNT_MAX) gap_count = gap_count + 16'd1;
            if (gap_count < gap_limit) return 1'b0;
            gap_running   = 1'b0;
            r.event_res   = mrgd_pkg::EVENT_TIMEOUT;
            r.error_total = bad_total;
            r.good_total  = good_total;
            return 1'b1;
        end
        errs   = {w.framing_err, w.overrun_err, w.parity_err};
        starts = !gap_running || (gap_count > gap_limit);
        gap_count   = '0;
        gap_running = 1'b1;
        if (errs != 3'd0) begin
            if (bad_total != mrgd_pkg::CNT_MAX) bad_total = bad_total + 16'd1;
        end else begin
            if (good_total != mrgd_pkg::CNT_MAX) good_total = good_total + 16'd1;
        end
        r.event_res   = mrgd_pkg::EVENT_BYTE;
        r.data_out    = w.rx_byte;
        r.frame_start = starts;
        r.any_error   = |errs;
        r.error_bits  = errs;
        r.error_total = bad_total;
        r.good_total  = good_total;
        return 1'b1;
    endfunction

    function automatic bit events_differ(input mrgd_pkg::t_result a,
                                         input mrgd_pkg::t_result b);
        return a.event_res !== b.event_res || a.data_out !== b.data_out
            || a.frame_start !== b.frame_start || a.any_error !== b.any_error
            || a.error_bits !== b.error_bits || a.error_total !== b.error_total
            || a.good_total !== b.good_total;
    endfunction

    task automatic log_mismatch(input string what, input mrgd_pkg::t_result want,
                                input mrgd_pkg::t_result got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%s at %0t: want ev=%0d data=%02h start=%0d err=%0d bits=%0d bad=%0d good=%0d",
                     what, $realtime, want.event_res, want.data_out, want.frame_start,
                     want.any_error, want.error_bits, want.error_total, want.good_total);
            $display("    got ev=%0d data=%02h start=%0d err=%0d bits=%0d bad=%0d good=%0d",
                     got.event_res, got.data_out, got.frame_start, got.any_error,
                     got.error_bits, got.error_total, got.good_total);
        end
    endtask

    function automatic int draw_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 88) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 15));
        return int'($urandom_range(30, 120));
    endfunction

    // Result checking, prediction of accepted words and the stall watchdog.
    always @(posedge i_clk) begin
        mrgd_pkg::t_result got;
        mrgd_pkg::t_result want;
        mrgd_pkg::t_item   seen;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            stall_cycles = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.event_res   = m_axis_tuser;
                got.data_out    = m_axis_tdata[7:0];
                got.frame_start = m_axis_tdata[8];
                got.any_error   = m_axis_tdata[9];
                got.error_bits  = m_axis_tdata[12:10];
                got.error_total = m_axis_tdata[28:13];
                got.good_total  = m_axis_tdata[44:29];
                if (expected_events.size() == 0) begin
                    log_mismatch("unexpected result word", '0, got);
                end else begin
                    want = expected_events.pop_front();
                    if (events_differ(want, got)) log_mismatch("result mismatch", want, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.kind        = s_axis_tuser;
                seen.rx_byte     = s_axis_tdata[7:0];
                seen.framing_err = s_axis_tdata[8];
                seen.overrun_err = s_axis_tdata[9];
                seen.parity_err  = s_axis_tdata[10];
                if (predict_gap_event(seen, want)) expected_events.push_back(want);
            end
            in_fire <= s_axis_tvalid && s_axis_tready;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Input side: the next word is offered once the current one has gone in.
    always @(negedge i_clk) begin
        mrgd_pkg::t_item w;
        if (!s_axis_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                s_axis_tuser  <= w.kind;
                s_axis_tdata  <= {5'b0, w.parity_err, w.overrun_err, w.framing_err, w.rx_byte};
                s_axis_tvalid <= 1'b1;
                tx_gap = tx_steady ? 0 : draw_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap = draw_gap();
        end
    end

    task automatic queue_word(input mrgd_pkg::t_item w);
        while (pending_words.size() >= QUEUE_DEPTH) @(negedge i_clk);
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic fe, input logic ov, input logic pe);
        mrgd_pkg::t_item w;
        w.kind        = mrgd_pkg::KIND_BYTE;
        w.rx_byte     = d;
        w.framing_err = fe;
        w.overrun_err = ov;
        w.parity_err  = pe;
        queue_word(w);
    endtask

    task automatic send_ticks(input int n);
        mrgd_pkg::t_item w;
        w = '0;
        w.kind = mrgd_pkg::KIND_TICK;
        repeat (n) queue_word(w);
    endtask

    task automatic send_data_byte(input bit bad);
        logic [2:0] e;
        e = bad ? 3'($urandom_range(1, 7)) : 3'd0;
        send_byte(8'($urandom_range(0, 255)), e[2], e[1], e[0]);
    endtask

    // Waits until every word has gone in and every result has come out.
    task automatic settle();
        while (pending_words.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_gap_ticks(input logic [15:0] value);
        logic [DATA_W-1:0] rd;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= GAP_TICKS_ADDR;
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        gap_limit = value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== gap_limit) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("gap_ticks read back %0d, want %0d", rd[15:0], gap_limit);
        end
    endtask

    // Mostly whole frames with silence after them, some random noise words.
    task automatic send_traffic(input int budget);
        int              first_count;
        int              nb;
        int              n;
        int              quiet;
        mrgd_pkg::t_item w;
        first_count = queued_words;
        while (queued_words - first_count < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                nb = int'($urandom_range(1, 8));
                for (int k = 0; k < nb; k++) begin
                    send_data_byte($urandom_range(0, 3) == 0);
                    if (k < nb - 1) begin
                        if ($urandom_range(0, 7) == 0 && gap_limit <= 64)
                            n = int'($urandom_range(0, int'(gap_limit) + 1));
                        else
                            n = int'($urandom_range(0, 2));
                        send_ticks(n);
                    end
                end
                if (gap_limit <= 64)
                    quiet = int'(gap_limit) + int'($urandom_range(0, 3));
                else
                    quiet = int'($urandom_range(1, 40));
                send_ticks(quiet);
            end else begin
                n = int'($urandom_range(1, 6));
                repeat (n) begin
                    w = mrgd_pkg::t_item'(ITEM_W'($urandom()));
                    queue_word(w);
                end
            end
        end
    endtask

    initial begin
        int unsigned phase_limits[5];
        phase_limits = '{1, 2, 6, 0, 24};
        phase_limits[3] = $urandom_range(3, 30);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register read-back of the reset threshold comes first.
        set_gap_ticks(mrgd_pkg::GAP_RESET);
        set_gap_ticks(16'd3);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b0, 1'b1, 1'b0);
        send_byte(8'h3C, 1'b1, 1'b0, 1'b0);
        send_ticks(4);
        send_byte(8'h81, 1'b0, 1'b0, 1'b0);
        send_ticks(2);
        send_byte(8'h7E, 1'b0, 1'b0, 1'b0);
        settle();

        // Lowering the threshold under a running count: first a byte, then a tick.
        set_gap_ticks(16'd10);
        send_byte(8'h11, 1'b0, 1'b0, 1'b0);
        send_ticks(6);
        settle();
        set_gap_ticks(16'd4);
        send_byte(8'h22, 1'b0, 1'b1, 1'b0);
        send_ticks(6);
        settle();
        set_gap_ticks(16'd10);
        send_byte(8'h33, 1'b0, 1'b0, 1'b0);
        send_ticks(6);
        settle();
        set_gap_ticks(16'd4);
        send_ticks(1);
        settle();

        // With a zero threshold the first tick after a byte stops the timer.
        set_gap_ticks(16'd0);
        send_byte(8'h44, 1'b0, 1'b0, 1'b0);
        send_ticks(1);
        send_byte(8'h55, 1'b0, 1'b0, 1'b0);
        send_byte(8'h66, 1'b1, 1'b0, 1'b1);
        settle();

        for (int p = 0; p < 5; p++) begin
            set_gap_ticks(16'(phase_limits[p]));
            tx_steady = (p == 2);
            rx_steady = (p == 2);
            if (p == 1) begin
                // The receiver holds off while bytes keep coming, so the block fills up.
                hold_req++;
                repeat (40) send_data_byte($urandom_range(0, 1) == 1);
            end
            send_traffic(100);
            settle();
        end

        // Full-scale threshold keeps the timer running, then a lower one stops it.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        set_gap_ticks(mrgd_pkg::CNT_MAX);
        send_byte(8'h99, 1'b0, 1'b0, 1'b0);
        send_ticks(20);
        send_byte(8'h9A, 1'b0, 1'b0, 1'b0);
        send_ticks(5);
        settle();
        set_gap_ticks(16'd2);
        send_ticks(1);
        settle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        set_gap_ticks(16'd5);
        send_traffic(30);
        settle();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
design/mrgd_pkg.sv
design/mrgd_tracker.sv
design/modbus_rtu_gap_detector.sv
tb/tb_modbus_rtu_gap_detector.sv
